// File: rtl/core/pblp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the per-level best-unused picker.
// Used by the picker top level; depends on nothing else.
package pblp_pkg;

    // Request kinds carried on the slave-side tuser.
    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

    // Result status carried on the master-side tuser.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Field widths.
    localparam int LEVEL_W = 6;
    localparam int SCORE_W = 32;
    localparam int ID_W    = 16;

    // Request tdata layout: level, entry_score, entry_id, zero padding.
    localparam int IN_LEVEL_LSB = 0;
    localparam int IN_SCORE_LSB = IN_LEVEL_LSB + LEVEL_W;
    localparam int IN_ID_LSB    = IN_SCORE_LSB + SCORE_W;
    localparam int IN_DATA_W    = 56;

    // Result tdata layout: picked_id, picked_score.
    localparam int OUT_DATA_W = ID_W + SCORE_W;

    // Only scores strictly above this floor qualify for a pop.
    localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -32'sd1000000000;

    // One stored list entry.
    typedef struct packed {
        logic                      used;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

endpackage

// File: rtl/core/per_level_best_unused_picker.sv
`timescale 1ns / 1ps
// Per-level best-unused picker: per-level scored lists with extract-max.
// Depends on pblp_pkg and pblp_ram.
//
// The block handles one request at a time and answers each with exactly one
// result. Begin and append read the level's count from the count memory and
// then update it, and the result then passes through S_OUT to the result
// register. A pop reads the level's entries from the entry memory, one entry
// per cycle through its single read port, to find the best unused entry, and
// then sweeps them a second time to mark every entry with the picked
// identifier as used. A pop that finds nothing skips the marking sweep.
// No clearing pass is needed after reset: level counts read as zero until a
// level is first written, and entries above a level's count are never read.
// The result register lets a new request be accepted while a result waits.
module per_level_best_unused_picker #(
    parameter int LEVELS            = 64,
    parameter int ENTRIES_PER_LEVEL = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [5:0] level, [37:6] entry_score, [53:38] entry_id, [55:54] zero
    input  logic [pblp_pkg::IN_DATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [pblp_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] picked_id, [47:16] picked_score
    output logic [pblp_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [pblp_pkg::STATUS_W-1:0]  m_tuser
);

    import pblp_pkg::*;

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVL_DEPTH = 1 << LVL_W;
    localparam int EIDX_W    = $clog2(ENTRIES_PER_LEVEL);
    localparam int CNT_W     = $clog2(ENTRIES_PER_LEVEL + 1);
    localparam int ADDR_W    = LVL_W + EIDX_W;
    localparam int ENT_DEPTH = 1 << ADDR_W;
    localparam int ENT_W     = $bits(entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES_PER_LEVEL);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // Control registers.
    logic [2:0]           state_reg, state_next;
    logic [LVL_DEPTH-1:0] cnt_vld_reg, cnt_vld_next;
    logic                 pend_reg, pend_next;
    logic                 found_reg, found_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload registers.
    logic [ACTION_W-1:0]       action_reg, action_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [ADDR_W-1:0]         maddr_reg, maddr_next;
    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [ID_W-1:0]           best_id_reg, best_id_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;
    logic signed [SCORE_W-1:0] res_score_reg, res_score_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [ID_W-1:0]           m_id_reg, m_id_next;
    logic signed [SCORE_W-1:0] m_score_reg, m_score_next;
    logic [STATUS_W-1:0]       m_status_reg, m_status_next;

    // Memory ports.
    logic              cnt_we;
    logic [LVL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              cnt_re;
    logic [LVL_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]  cnt_q;
    logic              ent_we;
    logic [ADDR_W-1:0] ent_waddr;
    entry_t            ent_wdata;
    logic              ent_re;
    logic [ADDR_W-1:0] ent_raddr;
    entry_t            ent_q;

    // Decoded helpers.
    logic              in_accept;
    logic              lvl_ok;
    logic [LVL_W-1:0]  lvl_idx;
    logic [CNT_W-1:0]  cnt_eff;
    logic              sweep_issue;
    logic              sweep_done;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign lvl_ok    = (32'(level_reg) < LEVELS);
    assign lvl_idx   = LVL_W'(level_reg);
    assign cnt_eff   = cnt_vld_reg[lvl_idx] ? cnt_q : '0;

    // The count read is launched with the request itself.
    assign cnt_re    = in_accept;
    assign cnt_raddr = LVL_W'(s_tdata[IN_LEVEL_LSB +: LEVEL_W]);

    // Entry sweeps issue one read per cycle and finish when the last
    // read has been consumed.
    assign sweep_issue = (idx_reg < cnt_reg);
    assign sweep_done  = !sweep_issue && !pend_reg;
    assign ent_raddr   = {lvl_idx, idx_reg[EIDX_W-1:0]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_score_reg, m_id_reg};
    assign m_tuser  = m_status_reg;

    pblp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (LVL_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_q)
    );

    pblp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_q)
    );

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cnt_vld_next    = cnt_vld_reg;
        pend_next       = 1'b0;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg;
        action_next     = action_reg;
        level_next      = level_reg;
        score_next      = score_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        maddr_next      = maddr_reg;
        best_score_next = best_score_reg;
        best_id_next    = best_id_reg;
        res_id_next     = res_id_reg;
        res_score_next  = res_score_reg;
        res_status_next = res_status_reg;
        m_id_next       = m_id_reg;
        m_score_next    = m_score_reg;
        m_status_next   = m_status_reg;

        cnt_we    = 1'b0;
        cnt_waddr = lvl_idx;
        cnt_wdata = cnt_eff + CNT_W'(1);
        ent_we    = 1'b0;
        ent_waddr = maddr_reg;
        ent_wdata = ent_q;
        ent_re    = 1'b0;

        // The result register empties when the consumer takes it.
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    action_next = s_tuser;
                    level_next  = s_tdata[IN_LEVEL_LSB +: LEVEL_W];
                    score_next  = s_tdata[IN_SCORE_LSB +: SCORE_W];
                    id_next     = s_tdata[IN_ID_LSB +: ID_W];
                    state_next  = S_CNT;
                end
            end

            S_CNT:
            begin
                // The level's count has arrived; act on the request.
                res_id_next     = '0;
                res_score_next  = '0;
                res_status_next = ST_OK;
                state_next      = S_OUT;
                priority if (action_reg == ACT_BEGIN)
                begin
                    if (lvl_ok)
                    begin
                        cnt_vld_next[lvl_idx] = 1'b0;
                    end
                end
                else if (action_reg == ACT_APPEND)
                begin
                    if (!lvl_ok || cnt_eff >= CNT_MAX)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ent_we                = 1'b1;
                        ent_waddr             = {lvl_idx, cnt_eff[EIDX_W-1:0]};
                        ent_wdata.used        = 1'b0;
                        ent_wdata.id          = id_reg;
                        ent_wdata.score       = score_reg;
                        cnt_we                = 1'b1;
                        cnt_vld_next[lvl_idx] = 1'b1;
                    end
                end
                else if (action_reg == ACT_POP)
                begin
                    if (!lvl_ok)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cnt_next        = cnt_eff;
                        idx_next        = '0;
                        found_next      = 1'b0;
                        best_score_next = SCORE_FLOOR;
                        best_id_next    = '0;
                        state_next      = S_SCAN;
                    end
                end
                else
                begin
                    res_status_next = ST_OK;
                end
            end

            S_SCAN:
            begin
                // Issue the next read of the level's entries.
                if (sweep_issue)
                begin
                    ent_re     = 1'b1;
                    idx_next   = idx_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    maddr_next = ent_raddr;
                end
                // Keep the first unused entry with the highest score.
                if (pend_reg && !ent_q.used && ($signed(ent_q.score) > best_score_reg))
                begin
                    best_score_next = ent_q.score;
                    best_id_next    = ent_q.id;
                    found_next      = 1'b1;
                end
                if (sweep_done)
                begin
                    idx_next = '0;
                    if (found_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        cnt_vld_next[lvl_idx] = 1'b0;
                        res_id_next           = '0;
                        res_score_next        = '0;
                        res_status_next       = ST_EMPTY;
                        state_next            = S_OUT;
                    end
                end
            end

            S_MARK:
            begin
                if (sweep_issue)
                begin
                    ent_re     = 1'b1;
                    idx_next   = idx_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    maddr_next = ent_raddr;
                end
                // Write back entries with the picked identifier as used.
                if (pend_reg && (ent_q.id == best_id_reg))
                begin
                    ent_we         = 1'b1;
                    ent_wdata.used = 1'b1;
                end
                if (sweep_done)
                begin
                    res_id_next     = best_id_reg;
                    res_score_next  = best_score_reg;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
            end

            S_OUT:
            begin
                // Move the result into the output register once it is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_id_next     = res_id_reg;
                    m_score_next  = res_score_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_vld_reg <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_vld_reg <= cnt_vld_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        level_reg      <= level_next;
        score_reg      <= score_next;
        id_reg         <= id_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        maddr_reg      <= maddr_next;
        best_score_reg <= best_score_next;
        best_id_reg    <= best_id_next;
        res_id_reg     <= res_id_next;
        res_score_reg  <= res_score_next;
        res_status_reg <= res_status_next;
        m_id_reg       <= m_id_next;
        m_score_reg    <= m_score_next;
        m_status_reg   <= m_status_next;
    end

    // Entry writes only come from an append or the marking sweep, and only
    // touch the list of the level being served.
    assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> ((state_reg == S_CNT) || (state_reg == S_MARK))
                   && (ent_waddr[ADDR_W-1:EIDX_W] == lvl_idx))
        else $error("entry write outside an append or marking sweep");

    // A marking write goes back to the entry read in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ent_we && (state_reg == S_MARK)) |-> (ent_waddr == $past(ent_raddr)))
        else $error("marking write does not match the preceding read");

    // Any status other than ok carries an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("failed request carries a non-zero result");

    // A level never holds more entries than its list has room for, and a
    // sweep never runs past the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CNT) |-> (cnt_eff <= CNT_MAX))
        and (((state_reg == S_SCAN) || (state_reg == S_MARK)) |-> (idx_reg <= cnt_reg)))
        else $error("level count or sweep index out of range");

endmodule

// File: rtl/core/pblp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; instantiated by the picker top level.
module pblp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port with a read enable.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
